### hw/rtl/bgw_pkg.sv
// ============================================================================
// bgw_pkg: shared types for the breadth-first graph walk engine
// Holds command and status codes and the request and status bundles that
// pass between the sequencer and the neighbor-list store.
// ============================================================================
package bgw_pkg;

    localparam int NODE_W = 4;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RESULT = 2'd2
    } status_t;

    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              rd;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] dest;
        logic [SLOT_W-1:0] slot;
    } adj_req_t;

    typedef struct packed {
        logic             full;
        logic [CNT_W-1:0] count;
    } adj_stat_t;

endpackage

### hw/rtl/bgw_adj_store.sv
// ============================================================================
// bgw_adj_store: per-node neighbor lists
// Keeps a fill count per node and a neighbor table memory with one write
// port and one registered read port. Appends, clears and reads entries.
// ============================================================================
module bgw_adj_store #(
    parameter int NODES      = 16,
    parameter int MAX_DEGREE = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bgw_pkg::adj_req_t           req,
    output bgw_pkg::adj_stat_t          stat,
    output logic [bgw_pkg::NODE_W-1:0]  rdata
);

    localparam int ACTIVE = (NODES < 16) ? NODES : 16;
    localparam int NW     = $clog2(ACTIVE);
    localparam int CW     = $clog2(MAX_DEGREE + 1);
    localparam int DW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEPTH  = ACTIVE * MAX_DEGREE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0]              count_reg [ACTIVE];
    logic [bgw_pkg::NODE_W-1:0] table_mem [DEPTH];
    logic [bgw_pkg::NODE_W-1:0] rdata_reg;
    logic [NW-1:0]              node_idx;
    logic [DW-1:0]              slot_idx;
    logic [CW-1:0]              cur_count;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;

    assign node_idx  = req.node[NW-1:0];
    assign slot_idx  = req.slot[DW-1:0];
    assign cur_count = count_reg[node_idx];
    assign wr_addr   = AW'(node_idx) * AW'(MAX_DEGREE) + AW'(cur_count);
    assign rd_addr   = AW'(node_idx) * AW'(MAX_DEGREE) + AW'(slot_idx);

    assign stat.count = bgw_pkg::CNT_W'(cur_count);
    assign stat.full  = (cur_count >= CW'(MAX_DEGREE));
    assign rdata      = rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (req.clr)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (req.wr)
        begin
            count_reg[node_idx] <= cur_count + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            table_mem[wr_addr] <= req.dest;
        end
        if (req.rd)
        begin
            rdata_reg <= table_mem[rd_addr];
        end
    end

endmodule

### hw/rtl/bfs_graph_walk_top.sv
// ============================================================================
// bfs_graph_walk_top: breadth-first search engine over a small graph
// Builds per-node neighbor lists from add-edge transfers and walks the graph
// from a start node, reporting reach, hop distance and predecessor per node.
// ============================================================================
// Add-edge, clear and unused commands return a single acknowledge
// transfer. A search walks the reached nodes in queue order, reading each
// stored neighbor entry through the single registered read port of the
// neighbor table and checking it, then returns R = min(NODES, 16) result
// transfers, one per node. The block takes no new input while a search
// is running. No clearing pass is needed after reset.
module bfs_graph_walk_top #(
    parameter int NODES      = 16,
    parameter int MAX_DEGREE = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // from_node[3:0], to_node[7:4]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // node_id[3:0], reached[4],
                                        // hop_distance[8:5], predecessor[12:9]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    localparam int ACTIVE = (NODES < 16) ? NODES : 16;
    localparam int NW     = $clog2(ACTIVE);
    localparam int PW     = $clog2(ACTIVE + 1);
    localparam int CW     = $clog2(MAX_DEGREE + 1);
    localparam logic [4:0]    NODE_LIM = 5'(ACTIVE);
    localparam logic [NW-1:0] LAST_K   = NW'(ACTIVE - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEQ  = 5'b00010,
        S_RD   = 5'b00100,
        S_CHK  = 5'b01000,
        S_RPT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        tail_reg, tail_next;
    logic [NW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        slot_reg, slot_next;
    logic [NW-1:0]        k_reg, k_next;
    logic [ACTIVE-1:0]    seen_reg, seen_next;
    logic [3:0]           hops_reg [ACTIVE];
    logic [NW-1:0]        pred_reg [ACTIVE];
    logic [NW-1:0]        fifo_reg [ACTIVE];

    logic                 m_valid_reg, m_valid_next;
    logic [15:0]          m_data_reg, m_data_next;
    logic [1:0]           m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;

    bgw_pkg::cmd_t        cmd;
    logic [3:0]           from_node;
    logic [3:0]           to_node;
    logic                 from_ok;
    logic                 to_ok;
    logic                 in_fire;
    logic                 out_free;
    logic                 has_edge;
    logic                 start_load;
    logic                 discover;
    logic [NW-1:0]        start_idx;
    logic [NW-1:0]        nb_idx;
    logic [3:0]           hop_inc;
    bgw_pkg::adj_req_t    adj_req;
    bgw_pkg::adj_stat_t   adj_stat;
    logic [3:0]           adj_rdata;

    assign cmd       = bgw_pkg::cmd_t'(s_axis_tuser);
    assign from_node = s_axis_tdata[3:0];
    assign to_node   = s_axis_tdata[7:4];
    assign from_ok   = ({1'b0, from_node} < NODE_LIM);
    assign to_ok     = ({1'b0, to_node} < NODE_LIM);
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    assign start_idx = from_node[NW-1:0];
    assign nb_idx    = adj_rdata[NW-1:0];
    assign hop_inc   = (hops_reg[cur_reg] == 4'hF) ? 4'hF : hops_reg[cur_reg] + 4'd1;
    assign has_edge  = (bgw_pkg::CNT_W'(slot_reg) < adj_stat.count);

    assign start_load = in_fire && (cmd == bgw_pkg::CMD_SEARCH) && from_ok;
    assign discover   = (state_reg == S_CHK) && !seen_reg[nb_idx];

    assign adj_req.wr   = in_fire && (cmd == bgw_pkg::CMD_ADD) && from_ok && to_ok
                          && !adj_stat.full;
    assign adj_req.clr  = in_fire && (cmd == bgw_pkg::CMD_CLEAR);
    assign adj_req.rd   = (state_reg == S_RD) && has_edge;
    assign adj_req.node = (state_reg == S_IDLE) ? from_node : bgw_pkg::NODE_W'(cur_reg);
    assign adj_req.dest = to_node;
    assign adj_req.slot = bgw_pkg::SLOT_W'(slot_reg);

    bgw_adj_store #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_adj_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (adj_req),
        .stat  (adj_stat),
        .rdata (adj_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        slot_next    = slot_reg;
        k_next       = k_reg;
        seen_next    = seen_reg;
        m_valid_next = m_axis_tready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == bgw_pkg::CMD_SEARCH)
                    begin
                        seen_next = '0;
                        head_next = '0;
                        tail_next = '0;
                        if (from_ok)
                        begin
                            seen_next[start_idx] = 1'b1;
                            tail_next = PW'(1);
                        end
                        state_next = S_DEQ;
                    end
                    else
                    begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        m_last_next  = 1'b1;
                        if ((cmd == bgw_pkg::CMD_ADD) && !adj_req.wr)
                        begin
                            m_user_next = bgw_pkg::ST_FULL;
                        end
                        else
                        begin
                            m_user_next = bgw_pkg::ST_OK;
                        end
                    end
                end
            end
            S_DEQ:
            begin
                if (head_reg == tail_reg)
                begin
                    k_next     = '0;
                    state_next = S_RPT;
                end
                else
                begin
                    cur_next   = fifo_reg[head_reg[NW-1:0]];
                    head_next  = head_reg + PW'(1);
                    slot_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = has_edge ? S_CHK : S_DEQ;
            end
            S_CHK:
            begin
                if (discover)
                begin
                    seen_next[nb_idx] = 1'b1;
                    tail_next = tail_reg + PW'(1);
                end
                slot_next  = slot_reg + CW'(1);
                state_next = S_RD;
            end
            S_RPT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[3:0] = bgw_pkg::NODE_W'(k_reg);
                    if (seen_reg[k_reg])
                    begin
                        m_data_next[4]    = 1'b1;
                        m_data_next[8:5]  = hops_reg[k_reg];
                        m_data_next[12:9] = bgw_pkg::NODE_W'(pred_reg[k_reg]);
                    end
                    m_user_next = bgw_pkg::ST_RESULT;
                    m_last_next = (k_reg == LAST_K);
                    if (k_reg == LAST_K)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + NW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cur_reg     <= '0;
            slot_reg    <= '0;
            k_reg       <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cur_reg     <= cur_next;
            slot_reg    <= slot_next;
            k_reg       <= k_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
        if (start_load)
        begin
            hops_reg[start_idx] <= '0;
            pred_reg[start_idx] <= start_idx;
            fifo_reg[0]         <= start_idx;
        end
        if (discover)
        begin
            hops_reg[nb_idx]              <= hop_inc;
            pred_reg[nb_idx]              <= cur_reg;
            fifo_reg[tail_reg[NW-1:0]]    <= nb_idx;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
